/* hw/rtl/ckar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckar_pkg
// shared types and codes for the cursor key auto-repeat block
// ----------------------------------------------------------------------------
package ckar_pkg;

  // field widths fixed by the item layout
  localparam int CNT_W  = 8;
  localparam int TIME_W = 20;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  // direction codes, two's complement
  localparam logic [1:0] DIR_REL      = 2'b00;
  localparam logic [1:0] DIR_FWD      = 2'b01;
  localparam logic [1:0] DIR_BACK     = 2'b11;
  // code -2, negative, so it counts as back
  localparam logic [1:0] DIR_BACK_ALT = 2'b10;

  // axis codes
  localparam logic AXIS_VERT  = 1'b0;
  localparam logic AXIS_HORIZ = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ITEM_COUNT   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FIRST_DELAY  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_REPEAT_PER   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] FIRST_DELAY_RST  = 20'd400000;
  localparam logic [CFG_W-1:0] REPEAT_PER_RST   = 20'd100000;

  typedef struct packed {
    logic              axis;
    logic [1:0]        direction;
    logic [TIME_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic             moved;
    logic [1:0]       move_dir;
    logic [CNT_W-1:0] cursor_pos;
  } out_item_t;

endpackage

/* hw/rtl/ckar_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckar_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface ckar_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ckar_qual.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckar_qual
// repeat qualifier for one axis: release, first press and held countdown
// ----------------------------------------------------------------------------
module ckar_qual #(
  parameter int TW = 24,
  parameter int VW = 20
) (
  input  logic [1:0]           dir,
  input  logic [1:0]           prev_dir,
  input  logic signed [TW-1:0] timer,
  input  logic [VW-1:0]        dt,
  input  logic [VW-1:0]        first_delay,
  input  logic [VW-1:0]        repeat_period,
  output logic [1:0]           prev_dir_nxt,
  output logic signed [TW-1:0] timer_nxt,
  output logic [1:0]           mv_dir
);

  // lowest timer value, -2^(TW-1), at both widths
  localparam logic signed [TW:0]   TMIN_WIDE = {2'b11, {(TW - 1){1'b0}}};
  localparam logic signed [TW-1:0] TMIN      = {1'b1, {(TW - 1){1'b0}}};

  logic signed [TW:0]   diff;
  logic signed [TW-1:0] sat;

  assign diff = {timer[TW-1], timer} - $signed({{(TW + 1 - VW){1'b0}}, dt});
  assign sat  = (diff < TMIN_WIDE) ? TMIN : diff[TW-1:0];

  always_comb begin
    prev_dir_nxt = dir;
    timer_nxt    = timer;
    mv_dir       = ckar_pkg::DIR_REL;
    if (dir == ckar_pkg::DIR_REL) begin
      timer_nxt = '0;
    end else if (dir != prev_dir) begin
      timer_nxt = $signed({{(TW - VW){1'b0}}, first_delay});
      mv_dir    = dir;
    end else if (sat[TW-1] || (sat == '0)) begin
      // at most one move per update, even far below zero
      timer_nxt = sat + $signed({{(TW - VW){1'b0}}, repeat_period});
      mv_dir    = dir;
    end else begin
      timer_nxt = sat;
    end
  end

endmodule

/* hw/rtl/ckar_cursor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckar_cursor
// clamps the vertical cursor into the item count and steps it with wrap
// ----------------------------------------------------------------------------
module ckar_cursor (
  input  logic [ckar_pkg::CNT_W-1:0] count,
  input  logic [ckar_pkg::CNT_W-1:0] cursor,
  input  logic [1:0]                 mv_dir,
  output logic [ckar_pkg::CNT_W-1:0] cursor_nxt
);

  logic [ckar_pkg::CNT_W-1:0] last_idx;
  logic [ckar_pkg::CNT_W-1:0] cur_c;
  logic [ckar_pkg::CNT_W:0]   cur_inc;

  assign last_idx = count - ckar_pkg::CNT_W'(1);
  assign cur_c    = (cursor >= count) ? last_idx : cursor;
  assign cur_inc  = {1'b0, cur_c} + (ckar_pkg::CNT_W + 1)'(1);

  always_comb begin
    cursor_nxt = cur_c;
    if (count == '0) begin
      cursor_nxt = '0;
    end else if (mv_dir == ckar_pkg::DIR_FWD) begin
      cursor_nxt = (cur_inc >= {1'b0, count}) ? '0 : cur_inc[ckar_pkg::CNT_W-1:0];
    end else if (mv_dir == ckar_pkg::DIR_BACK) begin
      cursor_nxt = (cur_c == '0) ? last_idx : cur_c - ckar_pkg::CNT_W'(1);
    end
  end

endmodule

/* hw/rtl/cursor_key_autorepeat_top.sv */
`timescale 1ns / 1ps
// an accepted input transaction passes the input register, then the result register, before its result is offered
// throughput: one transaction per cycle while the result register can advance
// a stalled output holds the pipe, the input side keeps taking items while a slot is free
// reset (rst_n low, synchronous) empties both stages, clears cursor, directions and timers
// and loads item_count 0, first delay 400000 us and repeat period 100000 us
// ----------------------------------------------------------------------------
// cursor_key_autorepeat_top
// typematic repeat qualifier for two axes with a wrapping vertical cursor
// ----------------------------------------------------------------------------
module cursor_key_autorepeat_top #(
  parameter int MAX_ITEMS = 255,
  parameter int TIME_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ckar_stream_if.sink                in_ch,
  ckar_stream_if.source              out_ch,
  input  logic                       cfg_we,
  input  logic [ckar_pkg::IDX_W-1:0] cfg_idx,
  input  logic [ckar_pkg::CFG_W-1:0] cfg_wdata
);

  // timer holds down to -2^(TIME_BITS+3), so four bits above the time width
  localparam int TW  = TIME_BITS + 4;
  // time values are kept modulo 2^VW, VW being the smaller of TIME_BITS and the field width
  localparam int VW  = (TIME_BITS < ckar_pkg::TIME_W) ? TIME_BITS : ckar_pkg::TIME_W;
  localparam int CAP = (MAX_ITEMS > 255) ? 255 : MAX_ITEMS;
  localparam logic [ckar_pkg::CNT_W-1:0] CAP_V = ckar_pkg::CNT_W'(CAP);

  // configuration registers
  logic [ckar_pkg::CNT_W-1:0] item_count_r;
  logic [VW-1:0]              first_delay_r;
  logic [VW-1:0]              repeat_per_r;

  // input stage
  logic                s1_valid_r;
  ckar_pkg::in_item_t  s1_item_r;

  // result stage
  logic                out_valid_r;
  ckar_pkg::out_item_t out_item_r;
  ckar_pkg::out_item_t out_item_nxt;

  // axis state
  logic [ckar_pkg::CNT_W-1:0] cursor_r;
  logic [1:0]                 vlast_r;
  logic signed [TW-1:0]       vtimer_r;
  logic [1:0]                 hlast_r;
  logic signed [TW-1:0]       htimer_r;

  logic                       adv;
  logic                       is_vert;
  logic                       cnt_zero;
  logic [ckar_pkg::CNT_W-1:0] count_eff;
  logic [1:0]                 dir_n;
  logic [1:0]                 sel_last;
  logic signed [TW-1:0]       sel_timer;
  logic [1:0]                 last_nxt;
  logic signed [TW-1:0]       timer_nxt;
  logic [1:0]                 q_mv;
  logic [1:0]                 mv;
  logic [ckar_pkg::CNT_W-1:0] cursor_step;

  // the stage ahead advances whenever the result register is empty or drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // the user must write config only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r  <= '0;
      first_delay_r <= ckar_pkg::FIRST_DELAY_RST[VW-1:0];
      repeat_per_r  <= ckar_pkg::REPEAT_PER_RST[VW-1:0];
    end else if (cfg_we) begin
      case (cfg_idx)
        ckar_pkg::CFG_ITEM_COUNT:  item_count_r  <= cfg_wdata[ckar_pkg::CNT_W-1:0];
        ckar_pkg::CFG_FIRST_DELAY: first_delay_r <= cfg_wdata[VW-1:0];
        ckar_pkg::CFG_REPEAT_PER:  repeat_per_r  <= cfg_wdata[VW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.data;
    end
  end

  // effective count saturates at the configured maximum
  assign count_eff = (item_count_r > CAP_V) ? CAP_V : item_count_r;
  assign cnt_zero  = (count_eff == '0);
  assign is_vert   = (s1_item_r.axis == ckar_pkg::AXIS_VERT);

  // direction by its sign: code -2 acts as back
  assign dir_n = s1_item_r.direction[1] ? ckar_pkg::DIR_BACK : s1_item_r.direction;

  assign sel_last  = is_vert ? vlast_r  : hlast_r;
  assign sel_timer = is_vert ? vtimer_r : htimer_r;

  ckar_qual #(
    .TW (TW),
    .VW (VW)
  ) u_qual (
    .dir           (dir_n),
    .prev_dir      (sel_last),
    .timer         (sel_timer),
    .dt            (s1_item_r.elapsed_us[VW-1:0]),
    .first_delay   (first_delay_r),
    .repeat_period (repeat_per_r),
    .prev_dir_nxt  (last_nxt),
    .timer_nxt     (timer_nxt),
    .mv_dir        (q_mv)
  );

  // empty list on the vertical axis: no move, cursor forced to 0, direction and timer left alone
  assign mv = (is_vert && cnt_zero) ? ckar_pkg::DIR_REL : q_mv;

  ckar_cursor u_cursor (
    .count      (count_eff),
    .cursor     (cursor_r),
    .mv_dir     (mv),
    .cursor_nxt (cursor_step)
  );

  always_comb begin
    out_item_nxt.moved      = (mv != ckar_pkg::DIR_REL);
    out_item_nxt.move_dir   = mv;
    out_item_nxt.cursor_pos = is_vert ? cursor_step : cursor_r;
  end

  // state update, one transaction per cycle while the result register can advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      vlast_r  <= ckar_pkg::DIR_REL;
      vtimer_r <= '0;
      hlast_r  <= ckar_pkg::DIR_REL;
      htimer_r <= '0;
    end else if (s1_valid_r && adv) begin
      if (is_vert) begin
        cursor_r <= cursor_step;
        if (!cnt_zero) begin
          vlast_r  <= last_nxt;
          vtimer_r <= timer_nxt;
        end
      end else begin
        hlast_r  <= last_nxt;
        htimer_r <= timer_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // after a vertical update with a nonempty list the cursor lies inside it
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && is_vert && !cnt_zero) |=> (cursor_r < $past(count_eff)))
    else $error("cursor left the item range");

  // moved flag and direction agree, and no move carries code -2
  a_move_coherent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.moved == (out_item_r.move_dir != ckar_pkg::DIR_REL))
                     && (out_item_r.move_dir != ckar_pkg::DIR_BACK_ALT)))
    else $error("inconsistent move result");

  // release on the horizontal axis clears its state
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && !is_vert && dir_n == ckar_pkg::DIR_REL)
    |=> (htimer_r == '0 && hlast_r == ckar_pkg::DIR_REL))
    else $error("release did not clear the horizontal axis");

  // a held item in the input stage is never dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("pending item lost");

  // an empty list leaves the vertical timer untouched
  a_empty_keeps_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && is_vert && cnt_zero) |=> $stable(vtimer_r))
    else $error("vertical timer changed with an empty list");

endmodule

/* tb/ckar_autorepeat_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckar_autorepeat_checker
// watches both channels and the register port, predicts each result of the
// auto-repeat block from its own axis state and compares in order
// ----------------------------------------------------------------------------
module ckar_autorepeat_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ckar_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ckar_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [ckar_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [ckar_pkg::CFG_W-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            moves_seen
);

  // lowest value a held-axis timer may reach after a subtraction
  localparam int TIMER_FLOOR = -(1 << (ckar_pkg::TIME_W + 3));

  logic [ckar_pkg::CNT_W-1:0] item_count;
  logic [ckar_pkg::CFG_W-1:0] first_delay;
  logic [ckar_pkg::CFG_W-1:0] repeat_period;

  int                  cursor;
  int                  prev_dir [2];
  int                  axis_timer [2];
  ckar_pkg::out_item_t motion_q [$];

  // typematic qualifier for one axis, returns the move direction or 0
  function automatic int repeat_qualify(input logic ax, input int dir, input int dt);
    int t;
    if (dir == 0) begin
      prev_dir[ax]   = 0;
      axis_timer[ax] = 0;
      return 0;
    end
    if (dir != prev_dir[ax]) begin
      prev_dir[ax]   = dir;
      axis_timer[ax] = int'(first_delay);
      return dir;
    end
    t = axis_timer[ax] - dt;
    if (t < TIMER_FLOOR) t = TIMER_FLOOR;
    if (t <= 0) begin
      axis_timer[ax] = t + int'(repeat_period);
      return dir;
    end
    axis_timer[ax] = t;
    return 0;
  endfunction

  function automatic ckar_pkg::out_item_t repeat_step(input ckar_pkg::in_item_t it);
    ckar_pkg::out_item_t r;
    int                  dir;
    int                  mv;
    int                  count;
    case (it.direction)
      ckar_pkg::DIR_REL: dir = 0;
      ckar_pkg::DIR_FWD: dir = 1;
      default:           dir = -1;
    endcase
    mv    = 0;
    count = int'(item_count);
    if (it.axis == ckar_pkg::AXIS_VERT) begin
      if (count == 0) begin
        cursor = 0;
      end else begin
        if (cursor >= count) cursor = count - 1;
        mv = repeat_qualify(ckar_pkg::AXIS_VERT, dir, int'(it.elapsed_us));
        if (mv > 0) cursor = (cursor + 1 >= count) ? 0 : cursor + 1;
        else if (mv < 0) cursor = (cursor == 0) ? count - 1 : cursor - 1;
      end
    end else begin
      mv = repeat_qualify(ckar_pkg::AXIS_HORIZ, dir, int'(it.elapsed_us));
    end
    r.moved      = (mv != 0);
    r.move_dir   = (mv > 0) ? ckar_pkg::DIR_FWD
                            : ((mv < 0) ? ckar_pkg::DIR_BACK : ckar_pkg::DIR_REL);
    r.cursor_pos = ckar_pkg::CNT_W'(cursor);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ckar_pkg::out_item_t want;
    if (!rst_n) begin
      item_count    = '0;
      first_delay   = ckar_pkg::FIRST_DELAY_RST;
      repeat_period = ckar_pkg::REPEAT_PER_RST;
      cursor        = 0;
      prev_dir[0]   = 0;
      prev_dir[1]   = 0;
      axis_timer[0] = 0;
      axis_timer[1] = 0;
      motion_q.delete();
      pending       = 0;
      fail_count    = 0;
      results_seen  = 0;
      moves_seen    = 0;
    end else begin
      // result side first, so a stray result never pairs with this edge's input
      if (out_valid && out_ready) begin
        results_seen++;
        if (motion_q.size() == 0) begin
          $error("result %0h arrived with nothing expected", out_data);
          fail_count++;
        end else begin
          want = motion_q.pop_front();
          if (out_data.moved !== want.moved) begin
            $error("moved: expected %0d, actual %0d", want.moved, out_data.moved);
            fail_count++;
          end
          if (out_data.move_dir !== want.move_dir) begin
            $error("move_dir: expected %0d, actual %0d", want.move_dir, out_data.move_dir);
            fail_count++;
          end
          if (out_data.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos,
                   out_data.cursor_pos);
            fail_count++;
          end
          if (want.moved) moves_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          ckar_pkg::CFG_ITEM_COUNT:  item_count    = cfg_wdata[ckar_pkg::CNT_W-1:0];
          ckar_pkg::CFG_FIRST_DELAY: first_delay   = cfg_wdata;
          ckar_pkg::CFG_REPEAT_PER:  repeat_period = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) motion_q.push_back(repeat_step(in_data));
      pending = motion_q.size();
    end
  end

endmodule

/* tb/cursor_key_autorepeat_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_key_autorepeat_top_test
// drives the key auto-repeat block with directed corner cases and held-key
// sequences over several register settings and idle patterns; a side checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module cursor_key_autorepeat_top_test;

  localparam int HOLD_CYCLES = 64;   // long receiver hold-off
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 96;
  localparam logic [ckar_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [ckar_pkg::IDX_W-1:0] cfg_idx;
  logic [ckar_pkg::CFG_W-1:0] cfg_wdata;
  logic                       in_took;

  int fail_count;
  int pending;
  int results_seen;
  int moves_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_served;
  int sent_count;
  int setting_count;

  // what the sender keeps holding per axis, so most items continue a press
  logic [1:0]                 held_code [2];
  logic [ckar_pkg::CFG_W-1:0] cur_first;
  logic [ckar_pkg::CFG_W-1:0] cur_period;

  ckar_stream_if #(.payload_t(ckar_pkg::in_item_t))  in_ch ();
  ckar_stream_if #(.payload_t(ckar_pkg::out_item_t)) out_ch ();

  cursor_key_autorepeat_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ckar_autorepeat_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data      (in_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_data     (out_ch.data),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .moves_seen   (moves_seen)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input acceptance as seen at the last rising edge, read by the sender at the falling edge
  always @(posedge clk) in_took <= in_ch.valid && in_ch.ready;

  // safety net far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("cursor_key_autorepeat_top_test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request so the pipe fills up
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic ckar_pkg::in_item_t make_item(input logic ax, input logic [1:0] code,
                                                   input logic [ckar_pkg::TIME_W-1:0] dt);
    ckar_pkg::in_item_t it;
    it.axis       = ax;
    it.direction  = code;
    it.elapsed_us = dt;
    return it;
  endfunction

  // elapsed times scaled to the current delays, so timers cross zero often
  function automatic logic [ckar_pkg::TIME_W-1:0] random_elapsed();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return ckar_pkg::TIME_W'($urandom_range(cur_period));
      3:       return ckar_pkg::TIME_W'($urandom_range(cur_first));
      4:       return ckar_pkg::TIME_W'($urandom_range(15));
      default: return ckar_pkg::TIME_W'($urandom());
    endcase
  endfunction

  // mostly keeps the key held on an axis, sometimes releases or changes it
  function automatic ckar_pkg::in_item_t random_item();
    logic       ax;
    logic [1:0] code;
    ax = 1'($urandom_range(1));
    if ($urandom_range(99) < 65 && held_code[ax] != ckar_pkg::DIR_REL) begin
      code = held_code[ax];
      // the other back encoding must count as the same held direction
      if (code[1] && $urandom_range(3) == 0) code[0] = ~code[0];
    end else begin
      code = 2'($urandom_range(3));
    end
    held_code[ax] = code;
    return make_item(ax, code, random_elapsed());
  endfunction

  // offer one transaction after a random gap and wait for its acceptance
  task automatic send_txn(input ckar_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    sent_count++;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  // drop valid, then wait until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [ckar_pkg::CNT_W-1:0] count,
                            input logic [ckar_pkg::CFG_W-1:0] delay,
                            input logic [ckar_pkg::CFG_W-1:0] period);
    cfg_we    <= 1'b1;
    cfg_idx   <= ckar_pkg::CFG_ITEM_COUNT;
    cfg_wdata <= ckar_pkg::CFG_W'(count);
    @(negedge clk);
    cfg_idx   <= ckar_pkg::CFG_FIRST_DELAY;
    cfg_wdata <= delay;
    @(negedge clk);
    cfg_idx   <= ckar_pkg::CFG_REPEAT_PER;
    cfg_wdata <= period;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_first  = delay;
    cur_period = period;
    setting_count++;
  endtask

  initial begin
    logic [ckar_pkg::CNT_W-1:0] count;
    logic [ckar_pkg::CFG_W-1:0] delay;
    logic [ckar_pkg::CFG_W-1:0] period;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = ckar_pkg::CFG_ITEM_COUNT;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked     = 0;
    sent_count     = 0;
    setting_count  = 0;
    held_code[0]   = ckar_pkg::DIR_REL;
    held_code[1]   = ckar_pkg::DIR_REL;
    cur_first      = ckar_pkg::FIRST_DELAY_RST;
    cur_period     = ckar_pkg::REPEAT_PER_RST;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: empty list, default delays
    // empty list, no move
    send_txn(make_item(ckar_pkg::AXIS_VERT, ckar_pkg::DIR_FWD, '0));
    // code -2 acts as back
    send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_BACK_ALT, TIME_MAX));
    // same direction, still waiting
    send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_BACK, 20'd300000));
    // timer hits exactly zero
    send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_BACK, 20'd100000));
    send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_REL, 20'd5));
    drain_results();

    // three entries, zero delays: wrap at both ends
    write_regs(8'd3, '0, '0);
    send_txn(make_item(ckar_pkg::AXIS_VERT, ckar_pkg::DIR_BACK, '0));   // 0 wraps to 2
    send_txn(make_item(ckar_pkg::AXIS_VERT, ckar_pkg::DIR_FWD, '0));    // 2 wraps to 0
    send_txn(make_item(ckar_pkg::AXIS_VERT, ckar_pkg::DIR_FWD, '0));    // held, repeats at once
    send_txn(make_item(ckar_pkg::AXIS_VERT, ckar_pkg::DIR_REL, TIME_MAX));
    drain_results();

    // full list, zero period: long elapsed times drive the timer to its floor
    write_regs(8'd255, '0, '0);
    repeat (10) send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_FWD, TIME_MAX));
    drain_results();

    // largest period: a floored timer stays negative for several updates
    write_regs(8'd2, '1, '1);
    repeat (5) send_txn(make_item(ckar_pkg::AXIS_HORIZ, ckar_pkg::DIR_FWD, '0));
    drain_results();

    // random phases: register settings crossed with idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin count = 8'd255; delay = '0; period = '0; end
        1: begin count = 8'd1; delay = '1; period = '1; end
        2: begin
          count  = '0;
          delay  = ckar_pkg::FIRST_DELAY_RST;
          period = ckar_pkg::REPEAT_PER_RST;
        end
        default: begin
          // small lists half of the time, so wraps and clamping come up often
          count  = ($urandom_range(1) == 0) ? ckar_pkg::CNT_W'($urandom_range(1, 6))
                                            : ckar_pkg::CNT_W'($urandom_range(255));
          delay  = ckar_pkg::CFG_W'($urandom_range(300000));
          period = ($urandom_range(3) == 0) ? ckar_pkg::CFG_W'($urandom())
                                            : ckar_pkg::CFG_W'($urandom_range(200000));
        end
      endcase
      write_regs(count, delay, period);

      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-pressure burst while the sender keeps offering
        if (p == 0 && n == 20) hold_asked++;
        send_txn(random_item());
      end
      drain_results();
    end

    $display("run covered %0d input transactions over %0d register settings",
             sent_count, setting_count);
    $display("%0d results checked, %0d of them moves", results_seen, moves_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("cursor_key_autorepeat_top_test passed");
    end else begin
      $display("cursor_key_autorepeat_top_test failed");
    end
    $finish;
  end

endmodule
